### rtl/qrt_pkg.sv
// Shared constants for the prime-power quadratic residue test.
// Stream payload layout used by the top level and its port checker.
`default_nettype none
package qrt_pkg;
    localparam int FIELD_BITS   = 32;              // width of value_n and prime_p on the port
    localparam int EXP_BITS     = 6;               // width of exponent_e
    localparam int S_TDATA_BITS = 72;              // 32 + 32 + 6, padded to bytes
    localparam int M_TDATA_BITS = 8;               // 2 flags, padded to a byte
    localparam int N_LSB        = 0;
    localparam int P_LSB        = 32;
    localparam int E_LSB        = 64;
    localparam int RES_BIT      = 0;               // is_residue
    localparam int ERR_BIT      = 1;               // range_error
endpackage
`default_nettype wire

### rtl/prime_power_quadratic_residue_test.sv
// Top level of the prime-power quadratic residue test.
// Depends on qrt_pkg, qrt_mul and qrt_div.
`default_nettype none
// Takes one request (n, p, e) at a time and answers whether n is a quadratic
// residue modulo p^e, or flags range_error when p^e does not fit in
// VALUE_BITS bits (p of 0 is flagged too). All arithmetic runs through one
// bit-serial multiplier and one restoring divider. The steps, in order: p^e
// by repeated multiplication, n mod p^e, removal of each p^2 factor, n mod p
// and Euler's criterion by square-and-multiply. p of 0 or 1 or e of 0 skip
// the arithmetic. A new request is taken as soon as the previous result is
// in the output register, even if it has not yet been taken.
module prime_power_quadratic_residue_test #(
    parameter int VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] value_n, [63:32] prime_p, [69:64] exponent_e, [71:70] zero
    input  logic [qrt_pkg::S_TDATA_BITS-1:0]  s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] is_residue, [1] range_error, [7:2] zero
    output logic [qrt_pkg::M_TDATA_BITS-1:0]  m_tdata
);
    localparam int W  = VALUE_BITS;
    localparam int EB = qrt_pkg::EXP_BITS;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_POW    = 13'b0000000000010,   // acc *= p, e times
        S_RED    = 13'b0000000000100,   // n %= p^e
        S_SQ     = 13'b0000000001000,   // p * p
        S_SQDIV  = 13'b0000000010000,   // strip p^2 factors
        S_DECIDE = 13'b0000000100000,
        S_NMODP  = 13'b0000001000000,
        S_EXP    = 13'b0000010000000,   // square-and-multiply step
        S_MULR   = 13'b0000100000000,
        S_DIVR   = 13'b0001000000000,
        S_MULB   = 13'b0010000000000,
        S_DIVB   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    // working registers
    logic [W-1:0]   n_reg, n_next;
    logic [W-1:0]   p_reg, p_next;
    logic [EB-1:0]  e_reg, e_next;
    logic [EB-1:0]  cnt_reg, cnt_next;     // remaining power steps
    logic [W-1:0]   acc_reg, acc_next;     // p^k, then p^2, then Euler accumulator
    logic [W-1:0]   b_reg, b_next;         // Euler base
    logic [W-1:0]   ex_reg, ex_next;       // Euler exponent, shifted down
    logic           res_reg, res_next;
    logic           err_reg, err_next;

    // shared unit launch
    logic           mul_go_reg, mul_go_next;
    logic           div_go_reg, div_go_next;
    logic [W-1:0]   mul_a_reg, mul_a_next;
    logic [W-1:0]   mul_b_reg, mul_b_next;
    logic [2*W-1:0] div_num_reg, div_num_next;
    logic [W-1:0]   div_den_reg, div_den_next;

    // output register
    logic           out_valid_reg, out_valid_next;
    logic           out_res_reg, out_res_next;
    logic           out_err_reg, out_err_next;

    logic           mul_done, div_done;
    logic [2*W-1:0] mul_prod, div_quo;
    logic [W-1:0]   div_rem;

    logic [W-1:0]   in_n, in_p, p_less1;
    logic [EB-1:0]  in_e, e_less2;

    assign in_n    = s_tdata[qrt_pkg::N_LSB +: W];
    assign in_p    = s_tdata[qrt_pkg::P_LSB +: W];
    assign in_e    = s_tdata[qrt_pkg::E_LSB +: EB];
    assign p_less1 = p_reg - 1'b1;
    assign e_less2 = e_reg - EB'(2);

    qrt_mul #(.W(W)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_go_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    qrt_div #(.W(W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go_reg),
        .num     (div_num_reg),
        .den     (div_den_reg),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        e_next         = e_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        b_next         = b_reg;
        ex_next        = ex_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        mul_go_next    = 1'b0;
        div_go_next    = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_res_next   = out_res_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_next   = in_n;
                    p_next   = in_p;
                    e_next   = in_e;
                    cnt_next = in_e;
                    res_next = 1'b0;
                    err_next = 1'b0;
                    acc_next = W'(1);
                    priority if (in_p == '0) begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end else if (in_p == W'(1) || in_e == '0) begin
                        // modulus 1: everything reduces to 0
                        res_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        mul_a_next  = W'(1);
                        mul_b_next  = in_p;
                        mul_go_next = 1'b1;
                        state_next  = S_POW;
                    end
                end
            end
            S_POW: begin
                if (mul_done) begin
                    if (mul_prod[2*W-1:W] != '0) begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end else begin
                        acc_next = mul_prod[W-1:0];
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == EB'(1)) begin
                            div_num_next = {{W{1'b0}}, n_reg};
                            div_den_next = mul_prod[W-1:0];
                            div_go_next  = 1'b1;
                            state_next   = S_RED;
                        end else begin
                            mul_a_next  = mul_prod[W-1:0];
                            mul_b_next  = p_reg;
                            mul_go_next = 1'b1;
                        end
                    end
                end
            end
            S_RED: begin
                if (div_done) begin
                    n_next = div_rem;
                    if (e_reg >= EB'(2)) begin
                        mul_a_next  = p_reg;
                        mul_b_next  = p_reg;
                        mul_go_next = 1'b1;
                        state_next  = S_SQ;
                    end else begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_SQ: begin
                // p^2 <= p^e here, so it fits the value width
                if (mul_done) begin
                    acc_next     = mul_prod[W-1:0];
                    div_num_next = {{W{1'b0}}, n_reg};
                    div_den_next = mul_prod[W-1:0];
                    div_go_next  = 1'b1;
                    state_next   = S_SQDIV;
                end
            end
            S_SQDIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_next = div_quo[W-1:0];
                        e_next = e_less2;
                        if (e_less2 >= EB'(2)) begin
                            div_num_next = {{W{1'b0}}, div_quo[W-1:0]};
                            div_den_next = acc_reg;
                            div_go_next  = 1'b1;
                        end else begin
                            state_next = S_DECIDE;
                        end
                    end else begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                priority if (n_reg == '0 || n_reg == W'(1) || e_reg == '0) begin
                    res_next   = 1'b1;
                    state_next = S_DONE;
                end else if (p_reg == W'(2)) begin
                    priority if (e_reg == EB'(1)) begin
                        res_next = 1'b1;
                    end else if (e_reg == EB'(2)) begin
                        res_next = !n_reg[1];
                    end else begin
                        res_next = (n_reg[2:0] == 3'd1);
                    end
                    state_next = S_DONE;
                end else begin
                    div_num_next = {{W{1'b0}}, n_reg};
                    div_den_next = p_reg;
                    div_go_next  = 1'b1;
                    state_next   = S_NMODP;
                end
            end
            S_NMODP: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        res_next   = 1'b0;
                        state_next = S_DONE;
                    end else begin
                        b_next     = div_rem;
                        acc_next   = W'(1);
                        ex_next    = {1'b0, p_less1[W-1:1]};
                        state_next = S_EXP;
                    end
                end
            end
            S_EXP: begin
                priority if (ex_reg == '0) begin
                    res_next   = (acc_reg <= W'(1));
                    state_next = S_DONE;
                end else if (ex_reg[0]) begin
                    mul_a_next  = acc_reg;
                    mul_b_next  = b_reg;
                    mul_go_next = 1'b1;
                    state_next  = S_MULR;
                end else begin
                    mul_a_next  = b_reg;
                    mul_b_next  = b_reg;
                    mul_go_next = 1'b1;
                    state_next  = S_MULB;
                end
            end
            S_MULR: begin
                if (mul_done) begin
                    div_num_next = mul_prod;
                    div_den_next = p_reg;
                    div_go_next  = 1'b1;
                    state_next   = S_DIVR;
                end
            end
            S_DIVR: begin
                if (div_done) begin
                    acc_next    = div_rem;
                    mul_a_next  = b_reg;
                    mul_b_next  = b_reg;
                    mul_go_next = 1'b1;
                    state_next  = S_MULB;
                end
            end
            S_MULB: begin
                if (mul_done) begin
                    div_num_next = mul_prod;
                    div_den_next = p_reg;
                    div_go_next  = 1'b1;
                    state_next   = S_DIVB;
                end
            end
            S_DIVB: begin
                if (div_done) begin
                    b_next     = div_rem;
                    ex_next    = {1'b0, ex_reg[W-1:1]};
                    state_next = S_EXP;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_res_next   = res_reg && !err_reg;
                    out_err_next   = err_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mul_go_reg    <= 1'b0;
            div_go_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mul_go_reg    <= mul_go_next;
            div_go_reg    <= div_go_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        p_reg       <= p_next;
        e_reg       <= e_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        b_reg       <= b_next;
        ex_reg      <= ex_next;
        res_reg     <= res_next;
        err_reg     <= err_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        out_res_reg <= out_res_next;
        out_err_reg <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    always_comb begin
        m_tdata                   = '0;
        m_tdata[qrt_pkg::RES_BIT] = out_res_reg;
        m_tdata[qrt_pkg::ERR_BIT] = out_err_reg;
    end
endmodule
`default_nettype wire

### rtl/qrt_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Standalone; used by the top level for p^e, p*p and the exponentiation.
`default_nettype none
module qrt_mul #(
    parameter int W = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] prod
);
    localparam int CW = $clog2(W + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [2*W-1:0] acc_reg, acc_next;
    logic [2*W-1:0] mc_reg, mc_next;
    logic [W-1:0]   ml_reg, ml_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        ml_next   = ml_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            acc_next  = '0;
            mc_next   = {{W{1'b0}}, a};
            ml_next   = b;
        end else if (busy_reg) begin
            if (ml_reg[0]) begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = {mc_reg[2*W-2:0], 1'b0};
            ml_next  = {1'b0, ml_reg[W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        ml_reg  <= ml_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule
`default_nettype wire

### rtl/qrt_div.sv
// Restoring divider, one quotient bit per cycle over a double-width dividend.
// Standalone; used by the top level for every reduction and division.
`default_nettype none
module qrt_div #(
    parameter int W = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [2*W-1:0] num,
    input  logic [W-1:0]   den,
    output logic           done,
    output logic [2*W-1:0] quo,
    output logic [W-1:0]   rem
);
    localparam int CW = $clog2(2 * W + 1);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [2*W-1:0] q_reg, q_next;
    logic [W-1:0]   r_reg, r_next;
    logic [W-1:0]   d_reg, d_next;
    logic [W:0]     trial;
    logic [W:0]     diff;

    assign trial = {r_reg, q_reg[2*W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(2 * W);
            q_next    = num;
            r_next    = '0;
            d_next    = den;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                r_next = diff[W-1:0];
                q_next = {q_reg[2*W-2:0], 1'b1};
            end else begin
                r_next = trial[W-1:0];
                q_next = {q_reg[2*W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;
endmodule
`default_nettype wire

### rtl/qrt_check.sv
// Port-level checker for the quadratic residue test, with its bind.
// Depends on qrt_pkg and the top level's ports.
`default_nettype none
module qrt_check (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [qrt_pkg::S_TDATA_BITS-1:0] s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [qrt_pkg::M_TDATA_BITS-1:0] m_tdata
);
    // held result stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no request taken right after another
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // an error never reports a residue
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[qrt_pkg::ERR_BIT] && m_tdata[qrt_pkg::RES_BIT]))
        else $error("error and residue both set");

    // after a zero prime request is taken, a stalled result stays stable
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[qrt_pkg::P_LSB +: qrt_pkg::FIELD_BITS] == '0
        |=> !m_tvalid || m_tready || $stable(m_tdata))
        else $error("zero prime mishandled");

    // pad bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[qrt_pkg::M_TDATA_BITS-1:2] == '0)
        else $error("nonzero pad bits");
endmodule

bind prime_power_quadratic_residue_test qrt_check u_qrt_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

### tb/prime_power_quadratic_residue_test_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for prime_power_quadratic_residue_test: random and corner
// requests, a behavioral residue predictor, in-order result checking.
// Depends on qrt_pkg and the RTL top level only.
module prime_power_quadratic_residue_test_tb;

    localparam int VBITS = 32;

    typedef struct packed {
        logic [5:0]  exp_e;
        logic [31:0] prime;
        logic [31:0] value;
    } qr_req_t;

    typedef struct packed {
        logic range_err;
        logic residue;
    } qr_ans_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [qrt_pkg::S_TDATA_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [qrt_pkg::M_TDATA_BITS-1:0] m_tdata;

    qr_req_t req_q[$];      // requests waiting to be driven
    qr_ans_t answer_q[$];   // predicted answers, oldest first
    int      errors = 0;
    bit      quiet = 1'b0;  // last part of the run: no idling on either side
    bit      hold_off = 1'b1;
    int      send_gap = 0;
    int      recv_gap = 0;

    always #6 aclk = ~aclk;

    prime_power_quadratic_residue_test #(.VALUE_BITS(VBITS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // base^ex mod m, 64-bit intermediates so products never wrap
    function automatic logic [63:0] pow_mod(logic [63:0] base, logic [63:0] ex,
                                            logic [63:0] m);
        logic [63:0] r;
        logic [63:0] b;
        r = 1 % m;
        b = base % m;
        while (ex != 0) begin
            if (ex[0]) r = (r * b) % m;
            b = (b * b) % m;
            ex = ex >> 1;
        end
        return r;
    endfunction

    function automatic qr_ans_t predict_residue(qr_req_t rq);
        qr_ans_t     a;
        logic [63:0] n;
        logic [63:0] p;
        logic [63:0] md;
        logic [63:0] sq;
        int          e;
        bit          ovf;
        bit          yes;
        a = '0;
        n = rq.value;
        p = rq.prime;
        e = rq.exp_e;
        if (p == 0) begin
            a.range_err = 1'b1;
            return a;
        end
        md = 1;
        ovf = 1'b0;
        if (p != 1) begin
            for (int i = 0; i < e && !ovf; i++) begin
                md = md * p;
                if (md > 64'hFFFF_FFFF) ovf = 1'b1;
            end
        end
        if (ovf) begin
            a.range_err = 1'b1;
            return a;
        end
        n = n % md;
        sq = p * p;
        while (e >= 2 && (n % sq) == 0) begin
            n = n / sq;
            e = e - 2;
        end
        if (n <= 1 || p == 1 || e == 0) yes = 1'b1;
        else if (p == 2) begin
            if (e == 1) yes = 1'b1;
            else if (e == 2) yes = (n % 4) <= 1;
            else yes = (n % 8) == 1;
        end else if ((n % p) == 0) yes = 1'b0;
        else yes = pow_mod(n, (p - 1) / 2, p) <= 1;
        a.residue = yes;
        return a;
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        $display("mismatch %s: got %0b expected %0b at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic add_req(logic [31:0] n, logic [31:0] p, logic [5:0] e);
        qr_req_t r;
        r.value = n;
        r.prime = p;
        r.exp_e = e;
        req_q = {req_q, r};
    endtask

    // driver: one request per handshake, random idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) answer_q = {answer_q, predict_residue(qr_req_t'(s_tdata[69:0]))};
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (req_q.size() > 0) begin
                s_tdata <= {2'b00, req_q.pop_front()};
                s_tvalid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 16);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected result", 1'b1, 1'b0);
                end else begin
                    qr_ans_t w;
                    w = answer_q.pop_front();
                    if (m_tdata[qrt_pkg::RES_BIT] !== w.residue)
                        report_mismatch("is_residue", m_tdata[qrt_pkg::RES_BIT], w.residue);
                    if (m_tdata[qrt_pkg::ERR_BIT] !== w.range_err)
                        report_mismatch("range_error", m_tdata[qrt_pkg::ERR_BIT],
                                        w.range_err);
                    if (m_tdata[7:2] !== 6'b0)
                        report_mismatch("pad bits", |m_tdata[7:2], 1'b0);
                end
            end
            // receiver stall: long hold-off first, then random bursts
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) recv_gap <= $urandom_range(1, 16);
            end
        end
    end

    // long receiver hold-off right after reset, so the block fills and stalls
    initial begin
        wait (aresetn);
        repeat (3000) @(posedge aclk);
        hold_off <= 1'b0;
    end

    function automatic logic [31:0] pick_prime();
        logic [31:0] small_primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 31, 97, 65537};
        logic [31:0] big_primes[4] = '{32'hFFFF_FFFB, 32'h7FFF_FFFF, 1000003, 2147483629};
        case ($urandom_range(0, 9))
            0: return big_primes[$urandom_range(0, 3)];
            1: return $urandom;                 // composite or anything
            2: return $urandom_range(0, 1);
            default: return small_primes[$urandom_range(0, 11)];
        endcase
    endfunction

    initial begin
        int wait_cnt;
        // directed corners
        add_req(0, 7, 1);
        add_req(1, 7, 1);
        add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        add_req(5, 0, 3);                       // zero prime
        add_req(5, 1, 63);                      // trivial modulus
        add_req(12345, 13, 0);                  // exponent zero
        add_req(3, 2, 1);
        add_req(3, 2, 2);
        add_req(5, 2, 2);
        add_req(9, 2, 3);
        add_req(17, 2, 5);
        add_req(7, 2, 31);
        add_req(7, 2, 32);                      // 2^32 overflows
        add_req(7, 3, 40);                      // exponent above 32
        add_req(7, 3, 63);
        add_req(49, 7, 2);                      // p^2 divides n
        add_req(14, 7, 2);                      // p divides n, once
        add_req(2, 7, 1);
        add_req(3, 7, 1);
        add_req(10, 15, 1);                     // composite p
        add_req(32'hAAAA_AAAA, 32'hFFFF_FFFB, 1);
        add_req(32'h5555_5555, 65537, 2);
        add_req(32'hFFFF_FFFF, 3, 20);
        // random part
        for (int i = 0; i < 217; i++) begin
            logic [31:0] p;
            logic [5:0]  e;
            p = pick_prime();
            e = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4));
            add_req($urandom, p, e);
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        wait (req_q.size() < 40);
        quiet = 1'b1;
        wait (req_q.size() == 0 && !s_tvalid);
        wait_cnt = 0;
        while (answer_q.size() != 0 && wait_cnt < 200000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (7000) @(posedge aclk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #100ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

### filelist.f
rtl/qrt_pkg.sv
rtl/qrt_mul.sv
rtl/qrt_div.sv
rtl/prime_power_quadratic_residue_test.sv
rtl/qrt_check.sv
tb/prime_power_quadratic_residue_test_tb.sv
